// ----- hdl/ccd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants of the click and double-click detector: field
// widths, event codes, table row layout and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package ccd_pkg;

  // table and position sizing
  localparam int CODE_COUNT = 512;
  localparam int POS_BITS   = 13;
  localparam int ADDR_W     = $clog2(CODE_COUNT);

  // fixed field widths
  localparam int CODE_W    = 9;
  localparam int MOD_W     = 4;
  localparam int TS_W      = 32;
  localparam int WIN_W     = 16;
  localparam int CFG_IDX_W = 3;

  // squared distance widths
  localparam int SQ_W  = 2 * POS_BITS;
  localparam int SUM_W = SQ_W + 1;

  // result queue
  localparam int RES_DEPTH = 2;
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  // event kind of an input item
  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_REPEAT  = 2'd2
  } mode_e;

  // kind of a result item
  typedef enum logic [1:0] {
    EV_KEY_DOWN    = 2'd0,
    EV_KEY_RELEASE = 2'd1,
    EV_CLICK       = 2'd2,
    EV_DOUBLE      = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_KEY_WIN    = 3'd1,
    CFG_MOUSE_WIN  = 3'd2,
    CFG_DBL_WIN    = 3'd3,
    CFG_RADIUS_SQ  = 3'd4
  } cfg_idx_e;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EVAL  = 2'd2
  } state_e;

  // one row of the per-code table
  typedef struct packed {
    logic [TS_W-1:0] press_time;
    logic [TS_W-1:0] release_time;
    logic            rel_valid;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // one result item
  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] code;
    logic [MOD_W-1:0]  mods;
    logic              last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;   // write a zero row at the clear address and advance
    logic accept;   // capture input item, read its row, square distances
    logic eval;     // evaluate, write row back, queue results
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last; // clear address is at the final row
    logic room;     // result queue can take this item's results
  } ctrl_st_t;

endpackage
`default_nettype wire

// ----- hdl/click_double_click_detector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// click_double_click_detector
// Turns key and mouse button press/release/repeat events into key-down,
// key-release, click and double-click events using a per-code timing table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | mode, from_mouse, code, modifiers,
//          |           |                       | timestamp, cursor_x, cursor_y
//  out     | output    | out_valid_o/out_ready_i | event_kind, event_code,
//          |           |                       | event_modifiers, last
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each item passes a read step, which reads its table row from the RAM, and an
// evaluate step, which writes the row back; the single RAM read port sets this.
// After reset a clear pass writes zero to all 512 rows with in_ready_o low;
// configuration writes are taken throughout.
// Results go to a two-entry queue, so the next item is taken while results
// wait; an item stalls in evaluation only until the queue has room for it.
// ----------------------------------------------------------------------------
module click_double_click_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic                          from_mouse_i,
  input  wire logic [ccd_pkg::CODE_W-1:0]    code_i,
  input  wire logic [ccd_pkg::MOD_W-1:0]     modifier_bits_i,
  input  wire logic [ccd_pkg::TS_W-1:0]      timestamp_i,
  input  wire logic [ccd_pkg::POS_BITS-1:0]  cursor_x_i,
  input  wire logic [ccd_pkg::POS_BITS-1:0]  cursor_y_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [1:0]                    event_kind_o,
  output logic      [ccd_pkg::CODE_W-1:0]    event_code_o,
  output logic      [ccd_pkg::MOD_W-1:0]     event_modifiers_o,
  output logic                               last_o,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ccd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ccd_pkg::WIN_W-1:0]     cfg_data_i
);
  import ccd_pkg::*;

  ctrl_cmd_t         cmd;
  ctrl_st_t          st;
  result_t           out_res;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  ccd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath
  ccd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .mode_i          (mode_i),
    .from_mouse_i    (from_mouse_i),
    .code_i          (code_i),
    .modifier_bits_i (modifier_bits_i),
    .timestamp_i     (timestamp_i),
    .cursor_x_i      (cursor_x_i),
    .cursor_y_i      (cursor_y_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_res_o       (out_res)
  );

  // per-code timing table
  ccd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CODE_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result fields
  assign event_kind_o      = out_res.kind;
  assign event_code_o      = out_res.code;
  assign event_modifiers_o = out_res.mods;
  assign last_o            = out_res.last;

`ifndef ASSERT_OFF
  // one item at a time: ready drops after an input transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // no input is taken during the clear pass
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !in_ready_o)
    else $error("input ready during table clear");

  // evaluation returns to idle
  a_eval_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |=> in_ready_o)
    else $error("controller did not return to idle after evaluation");

  // only a key release precedes a second result
  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> event_kind_o == EV_KEY_RELEASE)
    else $error("non-final result is not a key release");
`endif

endmodule
`default_nettype wire

// ----- hdl/ccd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/ccd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_ctrl
// Controller: clears the table after reset, then takes one input item at a
// time through a read step and an evaluate/write-back step.
// ----------------------------------------------------------------------------
module ccd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ccd_pkg::ctrl_st_t   st_i,
  output ccd_pkg::ctrl_cmd_t       cmd_o
);
  import ccd_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (st_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (st_i.room) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.eval = st_i.room;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/ccd_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_dp
// Datapath: configuration registers, captured input item, cursor distance
// squares, click/double-click evaluation, table write-back, last click
// position and a two-entry result queue.
// ----------------------------------------------------------------------------
module ccd_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command and status
  input  wire ccd_pkg::ctrl_cmd_t                cmd_i,
  output ccd_pkg::ctrl_st_t                      st_o,
  // input item
  input  wire logic [1:0]                        mode_i,
  input  wire logic                              from_mouse_i,
  input  wire logic [ccd_pkg::CODE_W-1:0]        code_i,
  input  wire logic [ccd_pkg::MOD_W-1:0]         modifier_bits_i,
  input  wire logic [ccd_pkg::TS_W-1:0]          timestamp_i,
  input  wire logic [ccd_pkg::POS_BITS-1:0]      cursor_x_i,
  input  wire logic [ccd_pkg::POS_BITS-1:0]      cursor_y_i,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  input  wire logic [ccd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ccd_pkg::WIN_W-1:0]         cfg_data_i,
  // table memory
  output logic                                   ram_we_o,
  output logic      [ccd_pkg::ADDR_W-1:0]        ram_waddr_o,
  output logic      [ccd_pkg::ROW_W-1:0]         ram_wdata_o,
  output logic                                   ram_re_o,
  output logic      [ccd_pkg::ADDR_W-1:0]        ram_raddr_o,
  input  wire logic [ccd_pkg::ROW_W-1:0]         ram_rdata_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output ccd_pkg::result_t                       out_res_o
);
  import ccd_pkg::*;

  // configuration registers
  logic             en_q;
  logic [WIN_W-1:0] key_win_q;
  logic [WIN_W-1:0] mouse_win_q;
  logic [WIN_W-1:0] dbl_win_q;
  logic [WIN_W-1:0] radius_q;

  // captured item
  logic [1:0]          mode_q;
  logic                mouse_q;
  logic [CODE_W-1:0]   code_q;
  logic [MOD_W-1:0]    mods_q;
  logic [TS_W-1:0]     ts_q;
  logic [POS_BITS-1:0] cx_q;
  logic [POS_BITS-1:0] cy_q;
  logic [SQ_W-1:0]     sqx_q;
  logic [SQ_W-1:0]     sqy_q;

  // last click position and clear address
  logic [POS_BITS-1:0] pos_x_q;
  logic [POS_BITS-1:0] pos_y_q;
  logic [ADDR_W-1:0]   clr_cnt_q;

  // result queue
  result_t          ent_q [RES_DEPTH];
  logic             head_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;

  // evaluation signals
  logic [POS_BITS-1:0] dx_abs, dy_abs;
  row_t                row_rd, row_wr;
  logic [TS_W-1:0]     held, gap, win;
  logic [SUM_W-1:0]    dist_sq;
  logic                in_range, near, dbl, we_eval;
  logic [CNT_W-1:0]    n_res;
  result_t             res0, res1;
  logic                pop, push;
  logic                wslot0;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      key_win_q   <= WIN_W'(200);
      mouse_win_q <= WIN_W'(150);
      dbl_win_q   <= WIN_W'(250);
      radius_q    <= WIN_W'(5);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:    en_q        <= cfg_data_i[0];
        CFG_KEY_WIN:   key_win_q   <= cfg_data_i;
        CFG_MOUSE_WIN: mouse_win_q <= cfg_data_i;
        CFG_DBL_WIN:   dbl_win_q   <= cfg_data_i;
        CFG_RADIUS_SQ: radius_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // distance to last click, per axis
  assign dx_abs = (cursor_x_i >= pos_x_q) ? cursor_x_i - pos_x_q : pos_x_q - cursor_x_i;
  assign dy_abs = (cursor_y_i >= pos_y_q) ? cursor_y_i - pos_y_q : pos_y_q - cursor_y_i;

  // capture item and squares on a transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= mode_i;
      mouse_q <= from_mouse_i;
      code_q  <= code_i;
      mods_q  <= modifier_bits_i;
      ts_q    <= timestamp_i;
      cx_q    <= cursor_x_i;
      cy_q    <= cursor_y_i;
      sqx_q   <= SQ_W'(dx_abs) * SQ_W'(dx_abs);
      sqy_q   <= SQ_W'(dy_abs) * SQ_W'(dy_abs);
    end
  end

  // evaluation of the captured item against its table row
  assign row_rd   = row_t'(ram_rdata_i);
  assign in_range = int'(code_q) < CODE_COUNT;
  assign held     = ts_q - row_rd.press_time;
  assign gap      = ts_q - row_rd.release_time;
  assign win      = TS_W'(mouse_q ? mouse_win_q : key_win_q);
  assign dist_sq  = SUM_W'(sqx_q) + SUM_W'(sqy_q);
  assign near     = dist_sq < SUM_W'(radius_q);
  assign dbl      = row_rd.rel_valid && (gap < TS_W'(dbl_win_q)) && (!mouse_q || near);

  always_comb begin
    n_res   = '0;
    res0    = '0;
    res1    = '0;
    row_wr  = row_rd;
    we_eval = 1'b0;
    res0.code = code_q;
    res1.code = code_q;
    if (en_q && in_range) begin
      case (mode_q)
        MODE_PRESS: begin
          row_wr.press_time = ts_q;
          we_eval   = 1'b1;
          n_res     = CNT_W'(1);
          res0.kind = EV_KEY_DOWN;
          res0.mods = mods_q;
          res0.last = 1'b1;
        end
        MODE_REPEAT: begin
          if (!mouse_q) begin
            n_res     = CNT_W'(1);
            res0.kind = EV_KEY_DOWN;
            res0.mods = mods_q;
            res0.last = 1'b1;
          end
        end
        MODE_RELEASE: begin
          we_eval   = 1'b1;
          res0.kind = EV_KEY_RELEASE;
          if (held >= win) begin
            // press too long: no click
            n_res               = CNT_W'(1);
            res0.last           = 1'b1;
            row_wr.release_time = ts_q;
            row_wr.rel_valid    = 1'b1;
          end else begin
            n_res     = CNT_W'(2);
            res1.last = 1'b1;
            if (dbl) begin
              res1.kind        = EV_DOUBLE;
              row_wr.rel_valid = 1'b0;
            end else begin
              res1.kind           = EV_CLICK;
              row_wr.release_time = ts_q;
              row_wr.rel_valid    = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // last mouse click position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (cmd_i.eval && mouse_q && (n_res == CNT_W'(2)) && !dbl) begin
      pos_x_q <= cx_q;
      pos_y_q <= cy_q;
    end
  end

  // clear address after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  // table memory ports
  assign ram_re_o    = cmd_i.accept;
  assign ram_raddr_o = ADDR_W'(code_i);
  assign ram_we_o    = cmd_i.clr_wr | (cmd_i.eval & we_eval);
  assign ram_waddr_o = cmd_i.clr_wr ? clr_cnt_q : ADDR_W'(code_q);
  assign ram_wdata_o = cmd_i.clr_wr ? '0 : ROW_W'(row_wr);

  // result queue: one or two pushed at once, one popped per transfer
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  assign push        = cmd_i.eval & (n_res != '0);
  assign wslot0      = head_q ^ cnt_q[0];
  assign cnt_d       = cnt_q + (cmd_i.eval ? n_res : '0) - CNT_W'(pop);
  assign out_res_o   = ent_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_q ^ pop;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wslot0] <= res0;
      if (n_res == CNT_W'(2)) begin
        ent_q[~wslot0] <= res1;
      end
    end
  end

  // status
  assign st_o.clr_last = (clr_cnt_q == ADDR_W'(CODE_COUNT - 1));
  assign st_o.room     = ({1'b0, cnt_q} + {1'b0, n_res}) <= (CNT_W + 1)'(RES_DEPTH);

endmodule
`default_nettype wire
